// ===== src/vrtc_pkg.sv =====
// Package for the virtual RTC rate divider: command codes and default constants.
package vrtc_pkg;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_OPEN  = 3'd1,
		CMD_CLOSE = 3'd2,
		CMD_ARM   = 3'd3,
		CMD_WRITE = 3'd4
	} cmd_t;

	localparam int MAX_RATE_DEF = 1024;
	localparam int MIN_RATE_DEF = 2;
	localparam int CHANNELS_DEF = 3;

	localparam int CMD_W      = 3;
	localparam int TERM_W     = 2;
	localparam int RATE_W     = 32;
	localparam int BYTES_W    = 8;
	localparam int MASK_W     = 3;
	localparam int REFRESH_W  = 8;
	localparam int WRITE_SIZE = 4;

endpackage

// ===== src/virtual_rtc_rate_divider.sv =====
// Virtual RTC rate divider: per-channel periodic counters, refresh and alarm pulses.
// Input register, then result register; the channel counters update in a single pass.
// Throughput: one item per cycle unless a result is held under out_stall.
// in_stall rises only while a result is held under out_stall.
// Reset (arst_n low, asynchronous): channels closed, wait flags set,
// counters, reloads, refresh and alarm tick counts cleared, no item in flight.
module virtual_rtc_rate_divider #(
	parameter int MAX_RATE = vrtc_pkg::MAX_RATE_DEF,
	parameter int MIN_RATE = vrtc_pkg::MIN_RATE_DEF,
	parameter int CHANNELS = vrtc_pkg::CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [vrtc_pkg::CMD_W-1:0]       command,
	input  logic [vrtc_pkg::TERM_W-1:0]      terminal,
	input  logic signed [vrtc_pkg::RATE_W-1:0] rate_value,
	input  logic [vrtc_pkg::BYTES_W-1:0]     byte_count,
	input  logic                             buffer_present,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             status,
	output logic [vrtc_pkg::MASK_W-1:0]      fired_mask,
	output logic [vrtc_pkg::MASK_W-1:0]      pending_flags,
	output logic                             alarm_pulse,
	output logic                             refresh_pulse
);

	localparam int CW = $clog2(MAX_RATE + 1);
	localparam int KW = (CW > 1) ? $clog2(CW) : 1;
	localparam int AW = $clog2(4 * MAX_RATE);
	localparam logic [CW-1:0] OPEN_DIV = CW'(MAX_RATE / 2);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_RATE);
	localparam logic [AW-1:0] ALARM_LAST = AW'(4 * MAX_RATE - 1);
	localparam logic [vrtc_pkg::REFRESH_W-1:0] REFRESH_LAST = '1;

	// input register
	logic                               valid_s1;
	logic [vrtc_pkg::CMD_W-1:0]         command_s1;
	logic [vrtc_pkg::TERM_W-1:0]        terminal_s1;
	logic signed [vrtc_pkg::RATE_W-1:0] rate_value_s1;
	logic [vrtc_pkg::BYTES_W-1:0]       byte_count_s1;
	logic                               buffer_present_s1;

	// channel state
	logic [CHANNELS-1:0] active_q, wait_q;
	logic [CW-1:0]       count_q  [CHANNELS];
	logic [CW-1:0]       reload_q [CHANNELS];
	logic [AW-1:0]       alarm_q;
	logic [vrtc_pkg::REFRESH_W-1:0] refresh_q;

	// result register
	logic                        valid_s2;
	logic                        status_s2;
	logic [vrtc_pkg::MASK_W-1:0] fired_s2, pending_s2;
	logic                        alarm_s2, refresh_s2;

	logic                         adv;
	logic                         go;
	logic [CHANNELS-1:0]          hit;
	logic                         write_ok;
	logic [KW-1:0]                shift_k;
	logic [CW-1:0]                write_div;
	logic [CHANNELS-1:0]          active_d, wait_d, fired_d;
	logic [CW-1:0]                count_d  [CHANNELS];
	logic [CW-1:0]                reload_d [CHANNELS];
	logic [CW-1:0]                dec;
	logic [AW-1:0]                alarm_d;
	logic [vrtc_pkg::REFRESH_W-1:0] refresh_d;
	logic                         status_d, alarm_hit, refresh_hit;
	logic [CHANNELS+vrtc_pkg::MASK_W-1:0] fired_pad, wait_pad;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = !adv;
	assign go       = valid_s1 && adv;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			hit[c] = ({1'b0, terminal_s1} == 3'(c));
		end
	end

	always_comb begin
		write_ok = buffer_present_s1 && (byte_count_s1 == vrtc_pkg::BYTES_W'(vrtc_pkg::WRITE_SIZE))
			&& (rate_value_s1 >= MIN_RATE) && (rate_value_s1 <= MAX_RATE)
			&& ((rate_value_s1 & (rate_value_s1 - 32'sd1)) == 32'sd0);
		shift_k = '0;
		for (int i = 0; i < CW; i++) begin
			if (rate_value_s1[i]) begin
				shift_k = shift_k | KW'(i);
			end
		end
		write_div = MAX_C >> shift_k;
	end

	always_comb begin
		active_d    = active_q;
		wait_d      = wait_q;
		fired_d     = '0;
		count_d     = count_q;
		reload_d    = reload_q;
		alarm_d     = alarm_q;
		refresh_d   = refresh_q;
		status_d    = 1'b0;
		alarm_hit   = 1'b0;
		refresh_hit = 1'b0;
		dec         = '0;
		case (command_s1)
			vrtc_pkg::CMD_TICK: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (count_q[c] != '0) begin
						dec = count_q[c] - CW'(1);
						if (dec == '0) begin
							wait_d[c]  = 1'b0;
							count_d[c] = reload_q[c];
							fired_d[c] = 1'b1;
						end else begin
							count_d[c] = dec;
						end
					end
				end
				refresh_hit = (refresh_q == REFRESH_LAST);
				refresh_d   = refresh_q + vrtc_pkg::REFRESH_W'(1);
				if (alarm_q >= ALARM_LAST) begin
					alarm_hit = 1'b1;
					alarm_d   = '0;
				end else begin
					alarm_d = alarm_q + AW'(1);
				end
			end
			vrtc_pkg::CMD_OPEN: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (hit[c]) begin
						active_d[c] = 1'b1;
						count_d[c]  = OPEN_DIV;
						reload_d[c] = OPEN_DIV;
					end
				end
			end
			vrtc_pkg::CMD_CLOSE: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (hit[c]) begin
						active_d[c] = 1'b0;
					end
				end
			end
			vrtc_pkg::CMD_ARM: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (hit[c] && active_q[c]) begin
						wait_d[c] = 1'b1;
					end
				end
			end
			vrtc_pkg::CMD_WRITE: begin
				status_d = !((|hit) && write_ok);
				for (int c = 0; c < CHANNELS; c++) begin
					if (hit[c] && write_ok) begin
						count_d[c]  = write_div;
						reload_d[c] = write_div;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign fired_pad = {{vrtc_pkg::MASK_W{1'b0}}, fired_d};
	assign wait_pad  = {{vrtc_pkg::MASK_W{1'b0}}, wait_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			command_s1        <= command;
			terminal_s1       <= terminal;
			rate_value_s1     <= rate_value;
			byte_count_s1     <= byte_count;
			buffer_present_s1 <= buffer_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			wait_q    <= '1;
			alarm_q   <= '0;
			refresh_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				count_q[c]  <= '0;
				reload_q[c] <= '0;
			end
		end else if (go) begin
			active_q  <= active_d;
			wait_q    <= wait_d;
			alarm_q   <= alarm_d;
			refresh_q <= refresh_d;
			count_q   <= count_d;
			reload_q  <= reload_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_s2  <= status_d;
			fired_s2   <= fired_pad[vrtc_pkg::MASK_W-1:0];
			pending_s2 <= wait_pad[vrtc_pkg::MASK_W-1:0];
			alarm_s2   <= alarm_hit;
			refresh_s2 <= refresh_hit;
		end
	end

	assign out_valid     = valid_s2;
	assign status        = status_s2;
	assign fired_mask    = fired_s2;
	assign pending_flags = pending_s2;
	assign alarm_pulse   = alarm_s2;
	assign refresh_pulse = refresh_s2;

	// an expiring channel always reports its wait flag cleared
	a_fired_clears_wait: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((fired_s2 & pending_s2) == '0))
		else $error("fired channel still pending");

	// a rejected write produces no tick side effects
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2) |-> (fired_s2 == '0 && !alarm_s2 && !refresh_s2))
		else $error("rejected write shows tick output");

	// refresh pulse leaves the refresh counter at zero
	a_refresh_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && refresh_s2 && $past(go)) |-> (refresh_q == '0))
		else $error("refresh counter not wrapped");

	// alarm counter stays within its period
	a_alarm_range: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_q <= ALARM_LAST)
		else $error("alarm counter out of range");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the virtual RTC rate divider: directed and random commands.
module testbench;

	localparam int NCH          = vrtc_pkg::CHANNELS_DEF;
	localparam int ALARM_PERIOD = 4 * vrtc_pkg::MAX_RATE_DEF;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic                        status;
		logic [vrtc_pkg::MASK_W-1:0] fired;
		logic [vrtc_pkg::MASK_W-1:0] pending;
		logic                        alarm;
		logic                        refresh;
	} divider_result_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic [vrtc_pkg::CMD_W-1:0]          command;
	logic [vrtc_pkg::TERM_W-1:0]         terminal;
	logic signed [vrtc_pkg::RATE_W-1:0]  rate_value;
	logic [vrtc_pkg::BYTES_W-1:0]        byte_count;
	logic                                buffer_present;
	logic                                out_valid;
	logic                                out_stall;
	logic                                status;
	logic [vrtc_pkg::MASK_W-1:0]         fired_mask;
	logic [vrtc_pkg::MASK_W-1:0]         pending_flags;
	logic                                alarm_pulse;
	logic                                refresh_pulse;

	// predicted block state
	logic chan_open [NCH];
	logic chan_wait [NCH];
	int   chan_left [NCH];
	int   chan_div  [NCH];
	int   alarm_count;
	int   refresh_count;

	divider_result_t expected_results[$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int mismatches         = 0;
	int results_checked    = 0;
	int cycle_count        = 0;
	int n_sent = 0, n_ticks = 0, n_rejects = 0, n_fired = 0, n_alarms = 0, n_refresh = 0;

	virtual_rtc_rate_divider dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.terminal       (terminal),
		.rate_value     (rate_value),
		.byte_count     (byte_count),
		.buffer_present (buffer_present),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.fired_mask     (fired_mask),
		.pending_flags  (pending_flags),
		.alarm_pulse    (alarm_pulse),
		.refresh_pulse  (refresh_pulse)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	function automatic divider_result_t predict_divider_result(
			logic [vrtc_pkg::CMD_W-1:0] cmd,
			logic [vrtc_pkg::TERM_W-1:0] term, logic signed [vrtc_pkg::RATE_W-1:0] rate,
			logic [vrtc_pkg::BYTES_W-1:0] bytes, logic present);
		divider_result_t r;
		logic in_range;
		r = '0;
		in_range = (term < NCH);
		case (cmd)
			vrtc_pkg::CMD_TICK: begin
				for (int c = 0; c < NCH; c++) begin
					if (chan_left[c] != 0) begin
						chan_left[c]--;
						if (chan_left[c] == 0) begin
							chan_wait[c] = 1'b0;
							chan_left[c] = chan_div[c];
							r.fired[c] = 1'b1;
						end
					end
				end
				if (refresh_count >= 255) begin
					r.refresh = 1'b1;
					refresh_count = 0;
				end else begin
					refresh_count++;
				end
				if (alarm_count >= ALARM_PERIOD - 1) begin
					r.alarm = 1'b1;
					alarm_count = 0;
				end else begin
					alarm_count++;
				end
			end
			vrtc_pkg::CMD_OPEN: begin
				if (in_range) begin
					chan_open[term] = 1'b1;
					chan_left[term] = vrtc_pkg::MAX_RATE_DEF / 2;
					chan_div[term] = vrtc_pkg::MAX_RATE_DEF / 2;
				end
			end
			vrtc_pkg::CMD_CLOSE: begin
				if (in_range)
					chan_open[term] = 1'b0;
			end
			vrtc_pkg::CMD_ARM: begin
				if (in_range && chan_open[term])
					chan_wait[term] = 1'b1;
			end
			vrtc_pkg::CMD_WRITE: begin
				if (in_range && present && bytes == vrtc_pkg::WRITE_SIZE
						&& rate >= vrtc_pkg::MIN_RATE_DEF
						&& rate <= vrtc_pkg::MAX_RATE_DEF && (rate & (rate - 1)) == 0) begin
					chan_left[term] = vrtc_pkg::MAX_RATE_DEF / int'(rate);
					chan_div[term] = chan_left[term];
				end else begin
					r.status = 1'b1;
				end
			end
			default: ;
		endcase
		for (int c = 0; c < NCH; c++)
			r.pending[c] = chan_wait[c];
		return r;
	endfunction

	task automatic send_item(logic [vrtc_pkg::CMD_W-1:0] cmd, logic [vrtc_pkg::TERM_W-1:0] term,
			logic [vrtc_pkg::RATE_W-1:0] rate, logic [vrtc_pkg::BYTES_W-1:0] bytes,
			logic present);
		divider_result_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		terminal <= term;
		rate_value <= rate;
		byte_count <= bytes;
		buffer_present <= present;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = predict_divider_result(cmd, term, rate, bytes, present);
		expected_results.push_back(r);
		n_sent++;
		if (cmd == vrtc_pkg::CMD_TICK)
			n_ticks++;
		n_rejects += r.status;
		n_fired += $countones(r.fired);
		n_alarms += r.alarm;
		n_refresh += r.refresh;
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		divider_result_t got;
		divider_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, fired_mask, pending_flags, alarm_pulse, refresh_pulse};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result %p", $time, got);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %0d mismatch, expected %p, got %p",
							$time, results_checked, want, got);
				end
			end
		end
	end

	task automatic test_idle_commands();
		send_item(vrtc_pkg::CMD_TICK, 2'd0, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_ARM, 2'd0, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_CLOSE, 2'd1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		for (int u = 5; u < 8; u++)
			send_item(3'(u), 2'd2, 32'd1024, 8'd4, 1'b1);
	endtask

	task automatic test_channel_commands();
		send_item(vrtc_pkg::CMD_OPEN, 2'd0, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_OPEN, 2'd3, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_ARM, 2'd3, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_CLOSE, 2'd3, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_WRITE, 2'd3, 32'd8, 8'd4, 1'b1);
	endtask

	task automatic test_rate_writes();
		send_item(vrtc_pkg::CMD_WRITE, 2'd0, 32'd1024, 8'd4, 1'b1);
		send_item(vrtc_pkg::CMD_TICK, 2'd0, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_ARM, 2'd0, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_WRITE, 2'd1, 32'd2, 8'd4, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'h8000_0000, 8'd4, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'h7FFF_FFFF, 8'd4, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'd1, 8'd4, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'd3, 8'd4, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'd1025, 8'd4, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'd4, 8'd0, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'd4, 8'hFF, 1'b1);
		send_item(vrtc_pkg::CMD_WRITE, 2'd2, 32'd4, 8'd4, 1'b0);
		send_item(vrtc_pkg::CMD_TICK, 2'd0, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_CLOSE, 2'd0, 32'd0, 8'd0, 1'b0);
		send_item(vrtc_pkg::CMD_ARM, 2'd0, 32'd0, 8'd0, 1'b0);
		pause_until_drained();
	endtask

	task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
		logic [vrtc_pkg::CMD_W-1:0]   cmd;
		logic [vrtc_pkg::TERM_W-1:0]  term;
		logic [vrtc_pkg::RATE_W-1:0]  rate;
		logic [vrtc_pkg::BYTES_W-1:0] bytes;
		logic                         present;
		int                           pick;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			term = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
			rate = $urandom;
			bytes = 8'($urandom);
			present = 1'($urandom);
			if (pick < 50) begin
				cmd = vrtc_pkg::CMD_TICK;
			end else if (pick < 58) begin
				cmd = vrtc_pkg::CMD_OPEN;
			end else if (pick < 63) begin
				cmd = vrtc_pkg::CMD_CLOSE;
			end else if (pick < 75) begin
				cmd = vrtc_pkg::CMD_ARM;
			end else if (pick < 95) begin
				cmd = vrtc_pkg::CMD_WRITE;
				if ($urandom_range(3) != 0) begin
					rate = 32'd1 << $urandom_range(1, 10);
					bytes = 8'(vrtc_pkg::WRITE_SIZE);
					present = 1'b1;
				end else if ($urandom_range(1) == 0) begin
					// near-miss writes around the legal range
					rate = $urandom_range(0, 1100);
					bytes = ($urandom_range(1) == 0) ? 8'(vrtc_pkg::WRITE_SIZE)
						: 8'($urandom_range(3, 5));
					present = ($urandom_range(3) != 0);
				end
			end else begin
				cmd = 3'($urandom_range(5, 7));
			end
			send_item(cmd, term, rate, bytes, present);
		end
		pause_until_drained();
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		command <= vrtc_pkg::CMD_TICK;
		terminal <= '0;
		rate_value <= '0;
		byte_count <= '0;
		buffer_present <= 1'b0;
		for (int c = 0; c < NCH; c++) begin
			chan_open[c] = 1'b0;
			chan_wait[c] = 1'b1;
			chan_left[c] = 0;
			chan_div[c] = 0;
		end
		alarm_count = 0;
		refresh_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_commands();
		test_channel_commands();
		test_rate_writes();
		test_random_traffic(360, 0, 0);
		test_random_traffic(360, 78, 0);
		test_random_traffic(360, 0, 78);
		test_random_traffic(360, 25, 25);

		repeat (8) @(posedge clk);
		mismatches += expected_results.size();
		$display("Sent %0d items (%0d ticks, %0d rejected writes), checked %0d results.",
			n_sent, n_ticks, n_rejects, results_checked);
		$display("Saw %0d channel expiries, %0d refresh pulses, %0d alarm pulses; %0d mismatches.",
			n_fired, n_refresh, n_alarms, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
